// File: hdl/chr_pkg.sv
// shared types and constants for the consistent hash ring table
package chr_pkg;

    localparam int KEY_W     = 34;
    localparam int OWNER_O_W = 8;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 7;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } chr_req_t;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } chr_state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             ins_en;
        logic             del_en;
        logic [KEY_W-1:0] key;
    } chr_cell_ctl_t;

    // summary of the compare flags across the ring
    typedef struct packed {
        logic hit;
        logic any_ge;
    } chr_ring_stat_t;

endpackage

// File: hdl/chr_cell.sv
// one ring slot: holds a key and its owner, compares and shifts with its neighbors
module chr_cell #(
    parameter int NODE_ID_BITS = 8
) (
    input  logic                        aclk,
    input  chr_pkg::chr_cell_ctl_t      ctl,
    input  logic                        occupied,
    input  logic [NODE_ID_BITS-1:0]     bowner,
    input  logic [chr_pkg::KEY_W-1:0]   left_key,
    input  logic [NODE_ID_BITS-1:0]     left_owner,
    input  logic                        left_after,
    input  logic [chr_pkg::KEY_W-1:0]   right_key,
    input  logic [NODE_ID_BITS-1:0]     right_owner,
    output logic [chr_pkg::KEY_W-1:0]   key_out,
    output logic [NODE_ID_BITS-1:0]     owner_out,
    output logic                        ge_out,
    output logic                        eq_out,
    output logic                        after_out
);
    import chr_pkg::*;

    logic [KEY_W-1:0]        key_reg, key_next;
    logic [NODE_ID_BITS-1:0] owner_reg, owner_next;
    logic                    ge_reg, eq_reg;
    logic                    after;

    // at or beyond the insert/lookup position
    assign after = ge_reg || !occupied;

    always_comb begin
        key_next   = key_reg;
        owner_next = owner_reg;
        if (ctl.ins_en && after) begin
            if (left_after) begin
                key_next   = left_key;
                owner_next = left_owner;
            end else begin
                key_next   = ctl.key;
                owner_next = bowner;
            end
        end else if (ctl.del_en && ge_reg) begin
            key_next   = right_key;
            owner_next = right_owner;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        owner_reg <= owner_next;
        if (ctl.cmp_en) begin
            ge_reg <= occupied && (key_reg >= ctl.key);
            eq_reg <= occupied && (key_reg == ctl.key);
        end
    end

    assign key_out   = key_reg;
    assign owner_out = owner_reg;
    assign ge_out    = ge_reg;
    assign eq_out    = eq_reg;
    assign after_out = after;

endmodule

// File: hdl/chr_ring.sv
// row of ring cells wired to their neighbors, plus the match summary
module chr_ring #(
    parameter int RING_DEPTH   = 64,
    parameter int NODE_ID_BITS = 8,
    parameter int CNT_W        = 7
) (
    input  logic                        aclk,
    input  chr_pkg::chr_cell_ctl_t      ctl,
    input  logic [NODE_ID_BITS-1:0]     bowner,
    input  logic [CNT_W-1:0]            count,
    output chr_pkg::chr_ring_stat_t     stat,
    output logic [NODE_ID_BITS-1:0]     sel_owner,
    output logic [NODE_ID_BITS-1:0]     head_owner
);
    import chr_pkg::*;

    logic [KEY_W-1:0]        keys   [RING_DEPTH];
    logic [NODE_ID_BITS-1:0] owners [RING_DEPTH];
    logic [RING_DEPTH-1:0]   ge, eq, after, occ, first;

    genvar i;
    generate
        for (i = 0; i < RING_DEPTH; i++) begin : g_cell
            logic [KEY_W-1:0]        lk, rk;
            logic [NODE_ID_BITS-1:0] lo, ro;
            logic                    la;

            assign occ[i] = CNT_W'(i) < count;

            if (i == 0) begin : g_head
                assign lk = '0;
                assign lo = '0;
                assign la = 1'b0;
            end else begin : g_body
                assign lk = keys[i-1];
                assign lo = owners[i-1];
                assign la = after[i-1];
            end

            if (i == RING_DEPTH - 1) begin : g_tail
                assign rk = keys[i];
                assign ro = owners[i];
            end else begin : g_mid
                assign rk = keys[i+1];
                assign ro = owners[i+1];
            end

            chr_cell #(.NODE_ID_BITS(NODE_ID_BITS)) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .occupied   (occ[i]),
                .bowner     (bowner),
                .left_key   (lk),
                .left_owner (lo),
                .left_after (la),
                .right_key  (rk),
                .right_owner(ro),
                .key_out    (keys[i]),
                .owner_out  (owners[i]),
                .ge_out     (ge[i]),
                .eq_out     (eq[i]),
                .after_out  (after[i])
            );
        end
    endgenerate

    // ge flags form a thermometer over the sorted keys, so its edge marks the first key at or above the query
    assign first = ge & ~{ge[RING_DEPTH-2:0], 1'b0};

    always_comb begin
        sel_owner = '0;
        for (int k = 0; k < RING_DEPTH; k++) begin
            sel_owner = sel_owner | (owners[k] & {NODE_ID_BITS{first[k]}});
        end
    end

    assign head_owner  = owners[0];
    assign stat.hit    = |eq;
    assign stat.any_ge = |ge;

endmodule

// File: hdl/consistent_hash_ring_table_unit.sv
// top level of the consistent hash ring table: request control, key count, result register
//
// Keeps up to RING_DEPTH hash keys in ascending order, each with an owner id.
// Requests enter on the s_ channel: insert (key, owner), delete (key) or
// lookup (key). Each request gives exactly one result on the m_ channel.
// A lookup returns the owner of the first key at or above the query key and
// wraps to the smallest key when none is that large; an empty ring reports
// status 4. Duplicate inserts, inserts into a full ring and deletes of absent
// keys leave the ring unchanged and report their status.
// Each request passes through accept, a compare step in which every cell
// compares its key with the broadcast key, and an apply step in which the
// cells shift and the result is written. A new request is accepted only in idle,
// once the previous one has left the apply step. The result register decouples
// the sides: a request is accepted while an earlier result still waits; if
// m_tready stays low the block holds in the apply step until the result
// register is free. Reset empties the ring (key count to zero) and drops any
// pending result.
module consistent_hash_ring_table_unit #(
    parameter int RING_DEPTH   = 64,
    parameter int NODE_ID_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [chr_pkg::S_TDATA_W-1:0]   s_tdata,  // ring_key[33:0], owner_id[41:34], zeros
    input  logic [chr_pkg::S_TUSER_W-1:0]   s_tuser,  // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [chr_pkg::M_TDATA_W-1:0]   m_tdata,  // found_owner[7:0], wrapped[8], entry_count[15:9]
    output logic [chr_pkg::M_TUSER_W-1:0]   m_tuser   // status[2:0]
);
    import chr_pkg::*;

    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    chr_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    chr_req_t                req_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [NODE_ID_BITS-1:0] owner_reg;

    logic                    m_valid_reg, m_valid_next;
    logic [OWNER_O_W-1:0]    found_reg, found_next;
    logic                    wrap_reg, wrap_next;
    logic [ENTRY_W-1:0]      entry_reg, entry_next;
    logic [STATUS_W-1:0]     status_reg, status_next;

    chr_cell_ctl_t           ctl;
    chr_ring_stat_t          stat;
    logic [NODE_ID_BITS-1:0] sel_owner, head_owner;
    logic                    out_free, accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg   <= chr_req_t'(s_tuser[REQ_W-1:0]);
            key_reg   <= s_tdata[KEY_W-1:0];
            owner_reg <= NODE_ID_BITS'(s_tdata[KEY_W +: OWNER_O_W]);
        end
        found_reg  <= found_next;
        wrap_reg   <= wrap_next;
        entry_reg  <= entry_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        found_next   = found_reg;
        wrap_next    = wrap_reg;
        entry_next   = entry_reg;
        status_next  = status_reg;
        ctl.cmp_en   = 1'b0;
        ctl.ins_en   = 1'b0;
        ctl.del_en   = 1'b0;
        ctl.key      = key_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctl.cmp_en = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    found_next   = '0;
                    wrap_next    = 1'b0;
                    status_next  = ST_OK;
                    unique case (req_reg)
                        REQ_INSERT: begin
                            if (stat.hit) begin
                                status_next = ST_DUP;
                            end else if (count_reg == CNT_W'(RING_DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                ctl.ins_en = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_DELETE: begin
                            if (stat.hit) begin
                                ctl.del_en = 1'b1;
                                count_next = count_reg - 1'b1;
                            end else begin
                                status_next = ST_ABSENT;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else if (stat.any_ge) begin
                                found_next = OWNER_O_W'(sel_owner);
                            end else begin
                                found_next = OWNER_O_W'(head_owner);
                                wrap_next  = 1'b1;
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                    entry_next = ENTRY_W'(count_next);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    chr_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .NODE_ID_BITS(NODE_ID_BITS),
        .CNT_W       (CNT_W)
    ) u_ring (
        .aclk      (aclk),
        .ctl       (ctl),
        .bowner    (owner_reg),
        .count     (count_reg),
        .stat      (stat),
        .sel_owner (sel_owner),
        .head_owner(head_owner)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {entry_reg, wrap_reg, found_reg};
    assign m_tuser  = status_reg;

endmodule

// File: hdl/chr_chk.sv
// port-level checks for the consistent hash ring table, bound to the top level
module chr_chk #(
    parameter int RING_DEPTH = 64
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [chr_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [chr_pkg::M_TUSER_W-1:0]   m_tuser
);
    import chr_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request at a time through compare and apply
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during compare");

    // an owner or a wrap only comes from a successful lookup
    a_owner_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[8] || (m_tdata[7:0] != '0)) |-> m_tuser == ST_OK)
        else $error("owner reported with bad status");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (RING_DEPTH < 128) |-> 32'(m_tdata[15:9]) <= RING_DEPTH)
        else $error("entry count above ring depth");

endmodule

bind consistent_hash_ring_table_unit chr_chk #(.RING_DEPTH(RING_DEPTH)) u_chr_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// File: bench/tb_consistent_hash_ring_table_unit.sv
// testbench for the consistent hash ring table: random and directed requests against a sorted-ring predictor
module tb_consistent_hash_ring_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import chr_pkg::*;

    localparam int                RING_SLOTS     = 64;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam logic [KEY_W-1:0]  KEY_MAX        = 34'd17179869180;

    typedef struct packed {
        logic [7:0]          owner;
        logic [STATUS_W-1:0] status;
        logic                wrapped;
        logic [ENTRY_W-1:0]  count;
    } ring_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // predicted ring contents, updated as each request is accepted
    logic [KEY_W-1:0]       model_keys[RING_SLOTS];
    logic [7:0]             model_owners[RING_SLOTS];
    int                     model_count;

    ring_result_t           pending_results[$];
    ring_result_t           head_result;
    int                     error_count;
    int                     idle_cycles;
    int                     hold_cycles;
    bit                     calm;

    consistent_hash_ring_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic ring_result_t ring_predict(chr_req_t req, logic [KEY_W-1:0] key,
                                                  logic [7:0] owner);
        ring_result_t res;
        int           pos;
        int           j;
        res = '0;
        pos = 0;
        while (pos < model_count && model_keys[pos] < key) pos++;
        case (req)
            REQ_INSERT: begin
                if (pos < model_count && model_keys[pos] == key) begin
                    res.status = ST_DUP;
                end else if (model_count >= RING_SLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    for (j = model_count; j > pos; j--) begin
                        model_keys[j]   = model_keys[j-1];
                        model_owners[j] = model_owners[j-1];
                    end
                    model_keys[pos]   = key;
                    model_owners[pos] = owner;
                    model_count++;
                end
            end
            REQ_DELETE: begin
                if (pos < model_count && model_keys[pos] == key) begin
                    for (j = pos; j + 1 < model_count; j++) begin
                        model_keys[j]   = model_keys[j+1];
                        model_owners[j] = model_owners[j+1];
                    end
                    model_count--;
                end else begin
                    res.status = ST_ABSENT;
                end
            end
            REQ_LOOKUP: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // no key at or above the query: wrap to the smallest
                    if (pos >= model_count) begin
                        pos         = 0;
                        res.wrapped = 1'b1;
                    end
                    res.owner = model_owners[pos];
                end
            end
            default: ;
        endcase
        res.count = 7'(model_count);
        return res;
    endfunction

    // often keys at or next to ones already in the ring, so hits and boundaries are common
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W:0] k;
        int             sel;
        sel = $urandom_range(0, 9);
        k = {3'b0, $urandom()} + {3'b0, $urandom()} + {3'b0, $urandom()} + {3'b0, $urandom()};
        if (sel < 4 && model_count > 0) begin
            k = {1'b0, model_keys[$urandom_range(0, model_count - 1)]};
            if (sel == 2 && k != '0) k = k - 35'd1;
            else if (sel == 3) k = k + 35'd1;
        end else if (sel == 4) begin
            k = 35'($urandom_range(0, 15));
        end else if (sel == 5) begin
            k = {1'b0, KEY_MAX} - 35'($urandom_range(0, 15));
        end
        if (k > {1'b0, KEY_MAX}) k = {1'b0, KEY_MAX};
        return k[KEY_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_request(chr_req_t req, logic [KEY_W-1:0] key, logic [7:0] owner);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {6'b0, owner, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(ring_predict(req, key, owner));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic random_requests(int n, int insert_pct, int delete_pct);
        int       r;
        chr_req_t req;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)                   req = REQ_INSERT;
            else if (r < insert_pct + delete_pct) req = REQ_DELETE;
            else if (r < 97)                      req = REQ_LOOKUP;
            else                                  req = REQ_NONE;
            send_request(req, pick_key(), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_empty_ring();
        send_request(REQ_LOOKUP, '0, 8'hff);
        send_request(REQ_LOOKUP, KEY_MAX, 8'h00);
        send_request(REQ_DELETE, 34'd5, 8'h00);
        send_request(REQ_NONE, KEY_MAX, 8'hff);
    endtask

    task automatic test_directed_edges();
        send_request(REQ_INSERT, '0, 8'h00);
        send_request(REQ_INSERT, KEY_MAX, 8'hff);
        send_request(REQ_INSERT, 34'h2_aaaa_aaaa, 8'h55);
        send_request(REQ_INSERT, 34'h1_5555_5555, 8'haa);
        send_request(REQ_INSERT, '0, 8'h77);             // duplicate key
        send_request(REQ_LOOKUP, '0, 8'h00);             // exact hit on smallest
        send_request(REQ_LOOKUP, 34'h2_aaaa_aaaa, 8'h00);
        send_request(REQ_LOOKUP, 34'h2_aaaa_aaab, 8'h00);
        send_request(REQ_LOOKUP, KEY_MAX, 8'h00);
        send_request(REQ_DELETE, KEY_MAX, 8'h00);
        send_request(REQ_LOOKUP, 34'h2_aaaa_aaab, 8'h00); // wraps to smallest
        send_request(REQ_DELETE, 34'd7, 8'h00);          // absent key
        send_request(REQ_NONE, 34'd1, 8'h12);
        send_request(REQ_DELETE, '0, 8'h00);
        send_request(REQ_DELETE, 34'h2_aaaa_aaaa, 8'h00);
        send_request(REQ_DELETE, 34'h1_5555_5555, 8'h00);
        send_request(REQ_LOOKUP, 34'h1_5555_5555, 8'h00); // empty again
    endtask

    task automatic test_full_ring();
        calm = 1'b1;
        while (model_count < RING_SLOTS)
            send_request(REQ_INSERT, pick_key(), 8'($urandom_range(0, 255)));
        calm = 1'b0;
        // new keys are dropped, present keys report duplicate first
        repeat (6) send_request(REQ_INSERT, pick_key(), 8'($urandom_range(0, 255)));
        repeat (4) send_request(REQ_INSERT, model_keys[$urandom_range(0, RING_SLOTS - 1)], 8'h3c);
        send_request(REQ_LOOKUP, KEY_MAX, 8'h00);
        send_request(REQ_LOOKUP, '0, 8'h00);
        random_requests(10, 0, 0);
        // shrink by deleting keys that are present
        while (model_count > 8)
            send_request(REQ_DELETE, model_keys[$urandom_range(0, model_count - 1)], 8'h00);
    endtask

    task automatic test_random_mix();
        random_requests(120, 60, 15);
        random_requests(100, 15, 55);
        calm = 1'b1;
        random_requests(50, 40, 30);
        calm = 1'b0;
        random_requests(80, 40, 30);
    endtask

    task automatic test_backpressure();
        // receiver stalls long while the sender keeps pushing requests
        hold_cycles = 120;
        calm        = 1'b1;
        random_requests(24, 45, 20);
        calm        = 1'b0;
        drain_results();
        random_requests(12, 40, 30);
    endtask

    // result side: random stalls, plus one long hold when asked
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 13);
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                head_result = pending_results.pop_front();
                if (m_tdata[7:0] !== head_result.owner)
                    report_mismatch($sformatf("found_owner %0d, want %0d",
                                              m_tdata[7:0], head_result.owner));
                if (m_tuser !== head_result.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_tuser, head_result.status));
                if (m_tdata[8] !== head_result.wrapped)
                    report_mismatch($sformatf("wrapped %0d, want %0d",
                                              m_tdata[8], head_result.wrapped));
                if (m_tdata[15:9] !== head_result.count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              m_tdata[15:9], head_result.count));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("[consistent_hash_ring_table_unit] ERROR");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        hold_cycles = 0;
        calm        = 1'b0;
        model_count = 0;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_ring();
        test_directed_edges();
        test_full_ring();
        test_random_mix();
        test_backpressure();

        drain_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("[consistent_hash_ring_table_unit] OK");
        end else begin
            $display("[consistent_hash_ring_table_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/chr_pkg.sv
hdl/chr_cell.sv
hdl/chr_ring.sv
hdl/consistent_hash_ring_table_unit.sv
hdl/chr_chk.sv
bench/tb_consistent_hash_ring_table_unit.sv
